>>> rtl/wpd_pkg.sv
// ----------------------------------------------------------------------------
// Worker pool dispatcher package
// Payload types, result and operation codes, and the microcode program of
// the dispatcher sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wpd_pkg;

   // Default sizes handed to the top level parameters.
   localparam int NUM_WORKERS_DEF   = 8;
   localparam int BACKLOG_DEPTH_DEF = 16;
   localparam int TAG_BITS_DEF      = 16;

   // An item never produces more than this many results.
   localparam int MAX_RESULTS = 8;

   // Input operations.
   localparam logic [1:0] OP_SUBMIT   = 2'd0;
   localparam logic [1:0] OP_REPLY    = 2'd1;
   localparam logic [1:0] OP_EXIT     = 2'd2;
   localparam logic [1:0] OP_SHUTDOWN = 2'd3;

   // Result kinds.
   localparam logic [2:0] KIND_DISPATCHED = 3'd0;
   localparam logic [2:0] KIND_COMPLETED  = 3'd1;
   localparam logic [2:0] KIND_QUEUED     = 3'd2;
   localparam logic [2:0] KIND_DROPPED    = 3'd3;
   localparam logic [2:0] KIND_CLOSE      = 3'd4;
   localparam logic [2:0] KIND_ABORTED    = 3'd5;
   localparam logic [2:0] KIND_ALARM      = 3'd6;

   // Alarm codes.
   localparam logic [1:0] ALARM_NONE     = 2'd0;
   localparam logic [1:0] ALARM_OVERLOAD = 2'd1;
   localparam logic [1:0] ALARM_TOO_FEW  = 2'd2;

   // One input item.
   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] tag;
      logic [2:0]  worker_id;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  alarm_code;
      logic [2:0]  worker;
      logic [15:0] result_tag;
      logic        last;
   } rsp_type;

   // Sequencer program counter width.
   localparam int PC_W = 4;

   // Datapath actions.
   localparam logic [3:0] ACT_NOP           = 4'd0;
   localparam logic [3:0] ACT_SUBMIT        = 4'd1;
   localparam logic [3:0] ACT_ALARM_OVL     = 4'd2;
   localparam logic [3:0] ACT_REPLY         = 4'd3;
   localparam logic [3:0] ACT_CLOSE_REPLIER = 4'd4;
   localparam logic [3:0] ACT_POP_DISPATCH  = 4'd5;
   localparam logic [3:0] ACT_EXIT          = 4'd6;
   localparam logic [3:0] ACT_ALARM_FEW     = 4'd7;
   localparam logic [3:0] ACT_SHUT_WORKER   = 4'd8;
   localparam logic [3:0] ACT_FINISH        = 4'd9;

   // Jump conditions.
   localparam logic [2:0] COND_NEVER     = 3'd0;
   localparam logic [2:0] COND_ALWAYS    = 3'd1;
   localparam logic [2:0] COND_NO_OVL    = 3'd2;
   localparam logic [2:0] COND_BAD_REPLY = 3'd3;
   localparam logic [2:0] COND_SHUT      = 3'd4;
   localparam logic [2:0] COND_NO_DRAIN  = 3'd5;
   localparam logic [2:0] COND_BAD_EXIT  = 3'd6;
   localparam logic [2:0] COND_MORE      = 3'd7;

   // Program steps.
   localparam logic [PC_W-1:0] STEP_SUBMIT      = 4'd0;
   localparam logic [PC_W-1:0] STEP_OVL         = 4'd1;
   localparam logic [PC_W-1:0] STEP_REPLY       = 4'd2;
   localparam logic [PC_W-1:0] STEP_REPLY_SHUT  = 4'd3;
   localparam logic [PC_W-1:0] STEP_DRAIN_CHK   = 4'd4;
   localparam logic [PC_W-1:0] STEP_DRAIN_POP   = 4'd5;
   localparam logic [PC_W-1:0] STEP_EXIT        = 4'd6;
   localparam logic [PC_W-1:0] STEP_EXIT_ALARM  = 4'd7;
   localparam logic [PC_W-1:0] STEP_SHUT_WALK   = 4'd8;
   localparam logic [PC_W-1:0] STEP_FIN         = 4'd9;

   // One control word: an action, a jump condition and its target.
   typedef struct packed {
      logic [3:0]      act;
      logic [2:0]      cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   // The program. A taken jump loads the target, otherwise the step advances.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         STEP_SUBMIT: begin
            w = '{act: ACT_SUBMIT, cond: COND_NO_OVL, target: STEP_FIN};
         end
         STEP_OVL: begin
            w = '{act: ACT_ALARM_OVL, cond: COND_ALWAYS, target: STEP_FIN};
         end
         STEP_REPLY: begin
            w = '{act: ACT_REPLY, cond: COND_BAD_REPLY, target: STEP_FIN};
         end
         STEP_REPLY_SHUT: begin
            w = '{act: ACT_CLOSE_REPLIER, cond: COND_SHUT, target: STEP_FIN};
         end
         STEP_DRAIN_CHK: begin
            w = '{act: ACT_NOP, cond: COND_NO_DRAIN, target: STEP_FIN};
         end
         STEP_DRAIN_POP: begin
            w = '{act: ACT_POP_DISPATCH, cond: COND_ALWAYS, target: STEP_DRAIN_CHK};
         end
         STEP_EXIT: begin
            w = '{act: ACT_EXIT, cond: COND_BAD_EXIT, target: STEP_FIN};
         end
         STEP_EXIT_ALARM: begin
            w = '{act: ACT_ALARM_FEW, cond: COND_ALWAYS, target: STEP_FIN};
         end
         STEP_SHUT_WALK: begin
            w = '{act: ACT_SHUT_WORKER, cond: COND_MORE, target: STEP_SHUT_WALK};
         end
         default: begin
            w = '{act: ACT_FINISH, cond: COND_NEVER, target: STEP_FIN};
         end
      endcase
      return w;
   endfunction

   // First step of the routine for each operation.
   function automatic logic [PC_W-1:0] op_entry(input logic [1:0] op);
      logic [PC_W-1:0] e;
      case (op)
         OP_SUBMIT: e = STEP_SUBMIT;
         OP_REPLY:  e = STEP_REPLY;
         OP_EXIT:   e = STEP_EXIT;
         default:   e = STEP_SHUT_WALK;
      endcase
      return e;
   endfunction

endpackage

>>> rtl/wpd_ram.sv
// ----------------------------------------------------------------------------
// Worker pool dispatcher RAM
// Generic single write port, single read port RAM with a registered read.
// A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/worker_pool_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// Worker pool dispatcher
// Submit adds an alarm step on overload, exit one unless bad; reply ends when stray,
// after the close step when the worker closes, else after a drain check and a pop
// per tag dispatched. Shutdown walks one step per worker. One item at a time; a
// result leaves in the cycle after the next is made, the last in the cycle after
// the final step. Results cannot be stalled. Synchronous reset opens an empty pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module worker_pool_dispatcher_unit #(
   parameter int NUM_WORKERS   = wpd_pkg::NUM_WORKERS_DEF,
   parameter int BACKLOG_DEPTH = wpd_pkg::BACKLOG_DEPTH_DEF,
   parameter int TAG_BITS      = wpd_pkg::TAG_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // Input items
   input  logic             start,
   output logic             busy,
   input  wpd_pkg::req_type req_data,
   // Result items
   output logic             rsp_strobe,
   output wpd_pkg::rsp_type rsp_data,
   // Configuration register
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [3:0]       csr_data
);

   localparam int NW    = NUM_WORKERS;
   localparam int WID_W = (NW > 1) ? $clog2(NW) : 1;
   localparam int RUN_W = $clog2(NW + 1);
   localparam int AW    = (BACKLOG_DEPTH > 1) ? $clog2(BACKLOG_DEPTH) : 1;
   localparam int CNT_W = $clog2(BACKLOG_DEPTH + 1);
   localparam int TAG_W = (TAG_BITS < 16) ? TAG_BITS : 16;
   localparam int CMP_W = ((CNT_W > RUN_W + 1) ? CNT_W : RUN_W + 1) + 1;
   localparam int RES_W = $clog2(wpd_pkg::MAX_RESULTS + 1);

   // Sequencer state.
   logic                    active_ff, active_in;
   logic [wpd_pkg::PC_W-1:0] pc_ff, pc_in;
   wpd_pkg::req_type        req_ff, req_in;
   logic [WID_W-1:0]        idx_ff, idx_in;
   logic [RES_W-1:0]        res_cnt_ff, res_cnt_in;

   // Pool state.
   logic [NW-1:0]           alive_ff, alive_in;
   logic [NW-1:0]           busyw_ff, busyw_in;
   logic [NW-1:0]           shut_ff, shut_in;
   logic [TAG_W-1:0]        held_ff [NW];
   logic                    held_wr_en;
   logic [WID_W-1:0]        held_wr_idx;
   logic [TAG_W-1:0]        held_wr_data;
   logic [AW-1:0]           head_ff, head_in;
   logic [AW-1:0]           tail_ff, tail_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [RUN_W-1:0]        run_ff, run_in;
   logic [RUN_W-1:0]        started_ff, started_in;

   // Result staging: one pending result and the output register.
   logic                    pend_valid_ff, pend_valid_in;
   wpd_pkg::rsp_type        pend_ff, pend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   wpd_pkg::rsp_type        rsp_ff, rsp_in;

   // Backlog RAM.
   logic                    ram_wr_en;
   logic [TAG_W-1:0]        ram_rd_data;

   // Decode and datapath signals.
   wpd_pkg::ucode_type      uw;
   logic                    accept;
   logic                    csr_write;
   logic [NW-1:0]           free_vec;
   logic                    ff_found;
   logic [WID_W-1:0]        ff_idx;
   logic [WID_W-1:0]        widx;
   logic                    wid_ok;
   logic                    reply_ok;
   logic                    exit_ok;
   logic                    full;
   logic                    overload;
   logic                    drain_ok;
   logic                    res_room;
   logic                    jump;
   logic [TAG_W-1:0]        req_tag;
   logic                    emit_en;
   wpd_pkg::rsp_type        emit_item;
   logic [3:0]              start_sat;

   assign uw        = wpd_pkg::ucode_rom(pc_ff);
   assign busy      = active_ff & (pc_ff != wpd_pkg::STEP_FIN);
   assign accept    = start & ~busy;
   assign csr_ready = ~busy;
   assign csr_write = csr_valid & csr_ready;

   // Lowest-numbered alive idle worker.
   assign free_vec = alive_ff & ~busyw_ff;
   assign ff_found = |free_vec;
   always_comb begin
      ff_idx = '0;
      for (int i = NW - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            ff_idx = WID_W'(i);
         end
      end
   end

   // Conditions on the latched item.
   assign widx     = WID_W'(req_ff.worker_id);
   assign wid_ok   = int'(req_ff.worker_id) < NW;
   assign reply_ok = wid_ok & alive_ff[widx] & busyw_ff[widx];
   assign exit_ok  = wid_ok & alive_ff[widx];
   assign full     = count_ff == CNT_W'(BACKLOG_DEPTH);
   assign overload = (CMP_W'(count_ff) + CMP_W'(1)) > (CMP_W'(run_ff) << 1);
   assign res_room = res_cnt_ff < RES_W'(wpd_pkg::MAX_RESULTS);
   assign drain_ok = (count_ff != '0) & ff_found & res_room;
   assign req_tag  = TAG_W'(req_ff.tag);

   // Saturated start count for a configuration write.
   assign start_sat = (int'(csr_data) > NW) ? 4'(NW) : csr_data;

   // Jump condition of the current control word.
   always_comb begin
      case (uw.cond)
         wpd_pkg::COND_NEVER:     jump = 1'b0;
         wpd_pkg::COND_ALWAYS:    jump = 1'b1;
         wpd_pkg::COND_NO_OVL:    jump = ff_found | full | ~overload;
         wpd_pkg::COND_BAD_REPLY: jump = ~reply_ok;
         wpd_pkg::COND_SHUT:      jump = shut_ff[widx];
         wpd_pkg::COND_NO_DRAIN:  jump = ~drain_ok;
         wpd_pkg::COND_BAD_EXIT:  jump = ~exit_ok;
         wpd_pkg::COND_MORE:      jump = idx_ff != WID_W'(NW - 1);
         default:                 jump = 1'b0;
      endcase
   end

   // Datapath actions, sequencing, configuration and result staging.
   always_comb begin
      active_in     = active_ff;
      pc_in         = pc_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      res_cnt_in    = res_cnt_ff;
      alive_in      = alive_ff;
      busyw_in      = busyw_ff;
      shut_in       = shut_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      run_in        = run_ff;
      started_in    = started_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      held_wr_en    = 1'b0;
      held_wr_idx   = ff_idx;
      held_wr_data  = req_tag;
      ram_wr_en     = 1'b0;
      emit_en       = 1'b0;
      emit_item     = '0;

      if (active_ff) begin
         case (uw.act)
            wpd_pkg::ACT_SUBMIT: begin
               emit_en = 1'b1;
               emit_item.result_tag = 16'(req_tag);
               if (ff_found) begin
                  busyw_in[ff_idx] = 1'b1;
                  held_wr_en       = 1'b1;
                  emit_item.kind   = wpd_pkg::KIND_DISPATCHED;
                  emit_item.worker = 3'(ff_idx);
               end else if (full) begin
                  emit_item.kind = wpd_pkg::KIND_DROPPED;
               end else begin
                  ram_wr_en      = 1'b1;
                  tail_in        = (tail_ff == AW'(BACKLOG_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                  count_in       = count_ff + 1'b1;
                  emit_item.kind = wpd_pkg::KIND_QUEUED;
               end
            end
            wpd_pkg::ACT_ALARM_OVL: begin
               emit_en              = 1'b1;
               emit_item.kind       = wpd_pkg::KIND_ALARM;
               emit_item.alarm_code = wpd_pkg::ALARM_OVERLOAD;
            end
            wpd_pkg::ACT_REPLY: begin
               if (reply_ok) begin
                  busyw_in[widx]       = 1'b0;
                  emit_en              = 1'b1;
                  emit_item.kind       = wpd_pkg::KIND_COMPLETED;
                  emit_item.worker     = req_ff.worker_id;
                  emit_item.result_tag = 16'(held_ff[widx]);
               end
            end
            wpd_pkg::ACT_CLOSE_REPLIER: begin
               // A worker asked to shut down retires on its reply.
               if (shut_ff[widx]) begin
                  alive_in[widx]   = 1'b0;
                  busyw_in[widx]   = 1'b0;
                  run_in           = (run_ff != '0) ? run_ff - 1'b1 : run_ff;
                  emit_en          = 1'b1;
                  emit_item.kind   = wpd_pkg::KIND_CLOSE;
                  emit_item.worker = req_ff.worker_id;
               end
            end
            wpd_pkg::ACT_POP_DISPATCH: begin
               busyw_in[ff_idx]     = 1'b1;
               held_wr_en           = 1'b1;
               held_wr_data         = ram_rd_data;
               head_in              = (head_ff == AW'(BACKLOG_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               count_in             = count_ff - 1'b1;
               emit_en              = 1'b1;
               emit_item.kind       = wpd_pkg::KIND_DISPATCHED;
               emit_item.worker     = 3'(ff_idx);
               emit_item.result_tag = 16'(ram_rd_data);
            end
            wpd_pkg::ACT_EXIT: begin
               if (exit_ok) begin
                  if (busyw_ff[widx]) begin
                     emit_en              = 1'b1;
                     emit_item.kind       = wpd_pkg::KIND_ABORTED;
                     emit_item.worker     = req_ff.worker_id;
                     emit_item.result_tag = 16'(held_ff[widx]);
                  end
                  alive_in[widx] = 1'b0;
                  busyw_in[widx] = 1'b0;
                  run_in         = (run_ff != '0) ? run_ff - 1'b1 : run_ff;
               end
            end
            wpd_pkg::ACT_ALARM_FEW: begin
               // An unrequested exit that leaves fewer than half the workers.
               if (!shut_ff[widx] && (run_ff < (started_ff >> 1))) begin
                  emit_en              = 1'b1;
                  emit_item.kind       = wpd_pkg::KIND_ALARM;
                  emit_item.alarm_code = wpd_pkg::ALARM_TOO_FEW;
                  emit_item.worker     = req_ff.worker_id;
               end
            end
            wpd_pkg::ACT_SHUT_WORKER: begin
               // Mark each alive worker; idle ones close while there is room for results.
               if (alive_ff[idx_ff]) begin
                  shut_in[idx_ff] = 1'b1;
                  if (!busyw_ff[idx_ff] && res_room) begin
                     alive_in[idx_ff] = 1'b0;
                     busyw_in[idx_ff] = 1'b0;
                     run_in           = (run_ff != '0) ? run_ff - 1'b1 : run_ff;
                     emit_en          = 1'b1;
                     emit_item.kind   = wpd_pkg::KIND_CLOSE;
                     emit_item.worker = 3'(idx_ff);
                  end
               end
               idx_in = idx_ff + 1'b1;
            end
            wpd_pkg::ACT_FINISH: begin
               // Release the pending result as the final one of the item.
               rsp_valid_in  = pend_valid_ff;
               rsp_in        = pend_ff;
               rsp_in.last   = 1'b1;
               pend_valid_in = 1'b0;
               active_in     = 1'b0;
            end
            default: begin
            end
         endcase

         pc_in = jump ? uw.target : pc_ff + 1'b1;
      end

      // A new result pushes the pending one out as a non-final result.
      if (emit_en) begin
         rsp_valid_in  = pend_valid_ff;
         rsp_in        = pend_ff;
         rsp_in.last   = 1'b0;
         pend_in       = emit_item;
         pend_valid_in = 1'b1;
         res_cnt_in    = res_cnt_ff + 1'b1;
      end

      // Accept a new item and enter the routine for its operation.
      if (accept) begin
         active_in  = 1'b1;
         pc_in      = wpd_pkg::op_entry(req_data.op);
         req_in     = req_data;
         idx_in     = '0;
         res_cnt_in = '0;
      end

      // A configuration write reopens the pool.
      if (csr_write) begin
         started_in = RUN_W'(start_sat);
         run_in     = RUN_W'(start_sat);
         for (int i = 0; i < NW; i++) begin
            alive_in[i] = i < int'(start_sat);
         end
         busyw_in = '0;
         shut_in  = '0;
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end
   end

   // Control and pool registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         pc_ff         <= wpd_pkg::STEP_FIN;
         idx_ff        <= '0;
         res_cnt_ff    <= '0;
         alive_ff      <= '0;
         busyw_ff      <= '0;
         shut_ff       <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         run_ff        <= '0;
         started_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         active_ff     <= active_in;
         pc_ff         <= pc_in;
         idx_ff        <= idx_in;
         res_cnt_ff    <= res_cnt_in;
         alive_ff      <= alive_in;
         busyw_ff      <= busyw_in;
         shut_ff       <= shut_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         run_ff        <= run_in;
         started_ff    <= started_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
      if (held_wr_en) begin
         held_ff[held_wr_idx] <= held_wr_data;
      end
   end

   // Backlog storage, read continuously at the head.
   wpd_ram #(
      .WIDTH (TAG_W),
      .DEPTH (BACKLOG_DEPTH)
   ) u_backlog (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (req_tag),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule
